### rtl/mi3_pkg.sv
package mi3_pkg;

  localparam int unsigned N_ELEM     = 9;
  localparam int unsigned FRAC_SHIFT = 24;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned QB         = 33;
  localparam int unsigned COF_LAT    = 4;
  localparam int unsigned LANE_LAT   = QB + 2;

  localparam logic [QB-1:0] Q_POS_MAX = 33'h0_7FFF_FFFF;
  localparam logic [QB-1:0] Q_NEG_MAX = 33'h0_8000_0000;
  localparam logic [RES_W-1:0] RES_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] RES_NEG_SAT = 32'h8000_0000;

  // adjugate entry k = a[MUL_L[2k]]*a[MUL_R[2k]] - a[MUL_L[2k+1]]*a[MUL_R[2k+1]]
  localparam int unsigned MUL_L [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned MUL_R [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage

### rtl/mi3_cofactor.sv
module mi3_cofactor #(
  parameter int unsigned EW = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [EW-1:0]   a   [mi3_pkg::N_ELEM],
  output logic signed [2*EW:0]   adj [mi3_pkg::N_ELEM],
  output logic signed [3*EW:0]   det
);

  localparam int unsigned AW = 2 * EW + 1;
  localparam int unsigned DW = 3 * EW + 1;

  logic signed [2*EW-1:0] p_r    [18];
  logic signed [EW-1:0]   row1_r [3];
  logic signed [EW-1:0]   row2_r [3];
  logic signed [AW-1:0]   adj2_r [mi3_pkg::N_ELEM];
  logic signed [AW-1:0]   adj3_r [mi3_pkg::N_ELEM];
  logic signed [AW-1:0]   adj4_r [mi3_pkg::N_ELEM];
  logic signed [DW-1:0]   dp_r   [3];
  logic signed [DW-1:0]   det_r;
  logic signed [DW+1:0]   det_sum;

  // products of the 2x2 minors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 18; i++) begin
        p_r[i] <= a[mi3_pkg::MUL_L[i]] * a[mi3_pkg::MUL_R[i]];
      end
      for (int j = 0; j < 3; j++) begin
        row1_r[j] <= a[j];
      end
    end
  end

  // adjugate entries
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        adj2_r[k] <= AW'(p_r[2*k]) - AW'(p_r[2*k+1]);
      end
      row2_r <= row1_r;
    end
  end

  // first-row expansion products
  always_ff @(posedge clk) begin
    if (en) begin
      dp_r[0] <= DW'(row2_r[0] * adj2_r[0]);
      dp_r[1] <= DW'(row2_r[1] * adj2_r[3]);
      dp_r[2] <= DW'(row2_r[2] * adj2_r[6]);
      adj3_r  <= adj2_r;
    end
  end

  assign det_sum = (DW+2)'(dp_r[0]) + (DW+2)'(dp_r[1]) + (DW+2)'(dp_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= det_sum[DW-1:0];
      adj4_r <= adj3_r;
    end
  end

  assign adj = adj4_r;
  assign det = det_r;

endmodule

### rtl/mi3_div_lane.sv
module mi3_div_lane #(
  parameter int unsigned EW = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [2*EW:0]               num,
  input  logic signed [3*EW:0]               den,
  output logic        [mi3_pkg::RES_W-1:0]   quo
);

  localparam int unsigned AW = 2 * EW + 1;
  localparam int unsigned DW = 3 * EW + 1;
  localparam int unsigned NB = AW + mi3_pkg::FRAC_SHIFT;
  localparam int unsigned QB = mi3_pkg::QB;

  logic [AW-1:0] nmag;
  logic [DW-1:0] dmag;
  logic [NB-1:0] nm0_r;
  logic [DW-1:0] dm0_r;
  logic          neg0_r;

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] lo_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic [DW-1:0] dm_r  [QB+1];
  logic          neg_r [QB+1];
  logic          sat_r [QB+1];

  logic [DW-1:0] hi;
  logic [QB-1:0] qf;
  logic [QB-1:0] qneg;

  assign nmag = num[AW-1] ? AW'(-num) : AW'(num);
  assign dmag = den[DW-1] ? DW'(-den) : DW'(den);

  // magnitudes, numerator scaled by the fraction shift
  always_ff @(posedge clk) begin
    if (en) begin
      nm0_r  <= {nmag, {mi3_pkg::FRAC_SHIFT{1'b0}}};
      dm0_r  <= dmag;
      neg0_r <= num[AW-1] ^ den[DW-1];
    end
  end

  // quotient would need more than QB bits: saturate
  assign hi = DW'(nm0_r[NB-1:QB]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi;
      lo_r[0]  <= nm0_r[QB-1:0];
      q_r[0]   <= '0;
      dm_r[0]  <= dm0_r;
      neg_r[0] <= neg0_r;
      sat_r[0] <= (hi >= dm0_r);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stg
    logic [DW:0] t;
    logic [DW:0] d;
    logic        ge;

    assign t  = {rem_r[k], lo_r[k][QB-1]};
    assign d  = t - {1'b0, dm_r[k]};
    assign ge = (t >= {1'b0, dm_r[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? d[DW-1:0] : t[DW-1:0];
        lo_r[k+1]  <= {lo_r[k][QB-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        dm_r[k+1]  <= dm_r[k];
        neg_r[k+1] <= neg_r[k];
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  assign qf   = q_r[QB];
  assign qneg = -qf;

  always_comb begin
    if (neg_r[QB]) begin
      quo = (sat_r[QB] || (qf > mi3_pkg::Q_NEG_MAX)) ? mi3_pkg::RES_NEG_SAT
                                                     : qneg[mi3_pkg::RES_W-1:0];
    end else begin
      quo = (sat_r[QB] || (qf > mi3_pkg::Q_POS_MAX)) ? mi3_pkg::RES_POS_SAT
                                                     : qf[mi3_pkg::RES_W-1:0];
    end
  end

endmodule

### rtl/matrix_inverse_3x3.sv
// channel | port group          | contents
// --------+---------------------+-----------------------------------------------
// input   | in_tvalid/tready    | one 3x3 matrix, nine signed Q8.8 elements
// result  | out_tvalid/tready   | nine Q16.16 inverse entries, Q24.24 determinant
//
// Takes one item every cycle unless the result is stalled; each item passes from
// acceptance to out_tvalid through the cofactor/determinant pipeline, the divider lanes
// (one quotient bit a stage over 33 bits) and the output register.
// rst_n (synchronous, active low) clears the valid pipe and the output flag.
// A stalled result freezes the whole pipe; in_tready is low only then.
module matrix_inverse_3x3 #(
  parameter int unsigned ELEM_WIDTH = 16,
  localparam int unsigned IN_W  = ((mi3_pkg::N_ELEM * ELEM_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W =
    ((mi3_pkg::N_ELEM * mi3_pkg::RES_W + 3 * ELEM_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22 (ELEM_WIDTH bits each), zero pad
  input  logic [IN_W-1:0]     in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (32 bits each), determinant, zero pad
  output logic [OUT_W-1:0]    out_tdata,
  // singular
  output logic                out_tuser
);

  localparam int unsigned EW    = ELEM_WIDTH;
  localparam int unsigned AW    = 2 * EW + 1;
  localparam int unsigned DW    = 3 * EW + 1;
  localparam int unsigned DET_LO = mi3_pkg::N_ELEM * mi3_pkg::RES_W;
  localparam int unsigned LAT   = mi3_pkg::COF_LAT + mi3_pkg::LANE_LAT;
  localparam int unsigned LL    = mi3_pkg::LANE_LAT;

  logic                          en;
  logic signed [EW-1:0]          a    [mi3_pkg::N_ELEM];
  logic signed [AW-1:0]          adj  [mi3_pkg::N_ELEM];
  logic signed [DW-1:0]          det;
  logic [mi3_pkg::RES_W-1:0]     quo  [mi3_pkg::N_ELEM];

  logic [LAT-1:0]                vld_r;
  logic [DW-1:0]                 det_d_r  [LL];
  logic                          sing_d_r [LL];
  logic                          out_valid_r;
  logic [OUT_W-1:0]              out_data_r;
  logic                          out_sing_r;
  logic [OUT_W-1:0]              merged;

  // advance everything whenever the output register is free or being drained
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  for (genvar i = 0; i < mi3_pkg::N_ELEM; i++) begin : g_unpack
    assign a[i] = in_tdata[i*EW +: EW];
  end

  mi3_cofactor #(.EW(EW)) u_cof (
    .clk (clk),
    .en  (en),
    .a   (a),
    .adj (adj),
    .det (det)
  );

  // one divider lane per inverse entry
  for (genvar i = 0; i < mi3_pkg::N_ELEM; i++) begin : g_lane
    mi3_div_lane #(.EW(EW)) u_lane (
      .clk (clk),
      .en  (en),
      .num (adj[i]),
      .den (det),
      .quo (quo[i])
    );
  end

  // carry determinant and singular flag alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      det_d_r[0]  <= det;
      sing_d_r[0] <= (det == '0);
      for (int s = 1; s < LL; s++) begin
        det_d_r[s]  <= det_d_r[s-1];
        sing_d_r[s] <= sing_d_r[s-1];
      end
    end
  end

  // merge: lanes plus determinant, zero entries on a singular matrix
  always_comb begin
    merged = '0;
    for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
      merged[i*mi3_pkg::RES_W +: mi3_pkg::RES_W] = sing_d_r[LL-1] ? '0 : quo[i];
    end
    merged[DET_LO +: DW] = det_d_r[LL-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= merged;
      out_sing_r <= sing_d_r[LL-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sing_r;

`ifndef NO_ASSERTIONS
  a_sing_det_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[DET_LO +: DW] == '0)
    else $error("singular result with nonzero determinant");

  a_sing_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[DET_LO-1:0] == '0)
    else $error("singular result with nonzero inverse entries");

  a_nonsing_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[DET_LO +: DW] != '0)
    else $error("zero determinant not flagged singular");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input held off with empty output register");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");
`endif

endmodule

### dv/mi3_checker.sv
module mi3_checker #(
  parameter int unsigned IN_W  = 144,
  parameter int unsigned OUT_W = 344
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tuser,
  output int               fail_count,
  output int               pending,
  output int               inverses_checked,
  output int               singular_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0][31:0] inv;
    logic [48:0]      det;
    logic             singular;
  } inverse_t;

  inverse_t inverse_q[$];

  function automatic logic [31:0] quotient_sat(longint signed num, longint signed den);
    logic            neg;
    longint unsigned mn;
    longint unsigned md;
    longint unsigned q;
    neg = (num < 0) ^ (den < 0);
    mn  = (num < 0) ? -num : num;
    md  = (den < 0) ? -den : den;
    q   = mn / md;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  function automatic inverse_t invert_matrix(logic [IN_W-1:0] d);
    longint signed a [9];
    longint signed adj [9];
    longint signed det;
    inverse_t      r;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(d[16*i +: 16]));
    adj[0] = a[4]*a[8] - a[5]*a[7];
    adj[1] = a[2]*a[7] - a[1]*a[8];
    adj[2] = a[1]*a[5] - a[2]*a[4];
    adj[3] = a[5]*a[6] - a[3]*a[8];
    adj[4] = a[0]*a[8] - a[2]*a[6];
    adj[5] = a[2]*a[3] - a[0]*a[5];
    adj[6] = a[3]*a[7] - a[4]*a[6];
    adj[7] = a[1]*a[6] - a[0]*a[7];
    adj[8] = a[0]*a[4] - a[1]*a[3];
    det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) r.inv[k] = quotient_sat(adj[k] <<< 24, det);
    r.det = det[48:0];
    return r;
  endfunction

  always @(posedge clk) begin
    inverse_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      fail_count       <= 0;
      pending          <= 0;
      inverses_checked <= 0;
      singular_seen    <= 0;
    end else begin
      if (in_tvalid && in_tready) inverse_q.push_back(invert_matrix(in_tdata));
      if (out_tvalid && out_tready) begin
        if (inverse_q.size() == 0) begin
          $error("result with no matrix outstanding");
          errs++;
        end else begin
          want = inverse_q.pop_front();
          inverses_checked <= inverses_checked + 1;
          if (want.singular) singular_seen <= singular_seen + 1;
          for (int k = 0; k < 9; k++)
            if (out_tdata[32*k +: 32] !== want.inv[k]) begin
              $error("r%0d%0d expected %h actual %h", k / 3, k % 3, want.inv[k],
                     out_tdata[32*k +: 32]);
              errs++;
            end
          if (out_tdata[288 +: 49] !== want.det) begin
            $error("determinant expected %h actual %h", want.det, out_tdata[288 +: 49]);
            errs++;
          end
          if (out_tuser !== want.singular) begin
            $error("singular expected %b actual %b", want.singular, out_tuser);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= inverse_q.size();
    end
  end

endmodule

### dv/tb_matrix_inverse_3x3.sv
module tb_matrix_inverse_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IN_W      = 144;  // nine 16-bit elements
  localparam int unsigned OUT_W     = 344;  // nine 32-bit entries, 49-bit det, pad
  localparam int unsigned N_RANDOM  = 1880;
  localparam int unsigned STALL_LIM = 5000;
  localparam int unsigned DRAIN     = 60;   // more than the pipeline latency

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  int fail_count, pending, inverses_checked, singular_seen;
  bit idle_on = 1'b1;     // random gaps on both sides
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  matrix_inverse_3x3 i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  mi3_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending, .inverses_checked, .singular_seen
  );

  // Result side: stall about a third of the cycles while idling is on.
  always @(posedge clk) begin
    out_tready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("matrix_inverse_3x3 test failed");
      $finish;
    end
  end

  // Hold the matrix on the bus until accepted; maybe leave a gap first.
  task automatic send_matrix(logic [8:0][15:0] m);
    if (idle_on) begin
      while ($urandom_range(99) < 33) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_diag(logic [15:0] d0, logic [15:0] d1, logic [15:0] d2);
    logic [8:0][15:0] m;
    m = '0;
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    send_matrix(m);
  endtask

  function automatic logic [15:0] pick_elem(int mode);
    case (mode)
      0:       return 16'($urandom_range(512) - 256);  // within about +-1.0
      1:       return 16'($urandom_range(8) - 4);      // tiny: drives saturation
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [8:0][15:0] m;
    int mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, identity, extremes, saturation both ways, singular cases.
    send_matrix('0);
    send_diag(16'h0100, 16'h0100, 16'h0100);
    send_diag(16'h0001, 16'h0001, 16'h0001);
    send_diag(16'hFFFF, 16'h0001, 16'h0001);
    send_diag(16'h8000, 16'h8000, 16'h8000);
    send_diag(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_diag(16'h8000, 16'h7FFF, 16'h0001);
    send_diag(16'h0100, 16'hFF00, 16'h0200);
    send_matrix({9{16'h7FFF}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'hFFFF}});
    m = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
         16'h7FFF, 16'h8000, 16'h7FFF};
    send_matrix(m);
    m = {16'h0001, 16'h8000, 16'h0000, 16'h7FFF, 16'h0001, 16'h8000,
         16'h0000, 16'h7FFF, 16'h0001};
    send_matrix(m);
    m = {16'h0300, 16'h0200, 16'h0100, 16'h0600, 16'h0400, 16'h0200,
         16'h0100, 16'hFF00, 16'h0500};                  // two rows in proportion
    send_matrix(m);
    m = {16'h0009, 16'h0008, 16'h0007, 16'h0006, 16'h0005, 16'h0004,
         16'h0003, 16'h0002, 16'h0001};                  // rank two
    send_matrix(m);
    send_diag(16'h0000, 16'h0100, 16'h0100);

    // Pause until the pipe has drained completely.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      idle_on = !(n >= 600 && n < 800);  // one long run at full rate
      mode = $urandom_range(9);
      for (int i = 0; i < 9; i++) m[i] = pick_elem(mode < 3 ? 0 : (mode < 5 ? 1 : 2));
      // Some singular matrices: copy one row over another, or zero a column.
      if ($urandom_range(9) == 0) begin
        for (int c = 0; c < 3; c++) m[3 + c] = m[c];
      end else if ($urandom_range(19) == 0) begin
        for (int r = 0; r < 3; r++) m[3*r + 2] = 16'h0000;
      end
      send_matrix(m);
    end
    in_tvalid <= 1'b0;
    idle_on = 1'b1;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("checked %0d inverses (%0d singular) over directed, random and full-rate items",
             inverses_checked, singular_seen);
    if (fail_count == 0 && pending == 0)
      $display("matrix_inverse_3x3 test passed");
    else
      $display("matrix_inverse_3x3 test failed");
    $finish;
  end

endmodule
